[design/drg_pkg.sv]
// Shared types, codes and constants of the duty ramp generator.
`default_nettype none

package drg_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int DUTY_W   = 16;
    localparam int MS_W     = 20;
    localparam int SEC_W    = 15;
    localparam int TICK_W   = 10;
    localparam int TIMER_W  = 26;
    localparam int HOLD_W   = 25;
    localparam int ACTION_W = 3;
    localparam int PHASE_W  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam int MS_PER_S = 1000;

    localparam logic [DUTY_W-1:0] TARGET_RST  = DUTY_W'(500);
    localparam logic [MS_W-1:0]   RAMP_MS_RST = MS_W'(10);
    localparam logic [SEC_W-1:0]  STEADY_RST  = SEC_W'(30);
    localparam logic [TICK_W-1:0] TICK_RST    = TICK_W'(20);

    typedef enum logic [PHASE_W-1:0] {
        PH_WAIT   = 3'd0,
        PH_UP     = 3'd1,
        PH_STEADY = 3'd2,
        PH_DOWN   = 3'd3,
        PH_CHANGE = 3'd4
    } phase_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK   = 3'd0,
        ACT_UP     = 3'd1,
        ACT_DOWN   = 3'd2,
        ACT_STOP   = 3'd3,
        ACT_CHANGE = 3'd4
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET  = 3'd0,
        REG_UP_MS   = 3'd1,
        REG_DOWN_MS = 3'd2,
        REG_STEADY  = 3'd3,
        REG_FOREVER = 3'd4,
        REG_TICK    = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

[design/drg_div.sv]
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none

module drg_div #(
    parameter int DW = 32,
    parameter int VW = 20
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DW-1:0]     dividend,
    input  wire logic [VW-1:0]     divisor,
    output logic      [DW-1:0]     quotient,
    output drg_pkg::div_stat_t     status
);

    localparam int CNT_W = $clog2(DW + 1);

    logic [DW-1:0]    quo_reg, quo_next;
    logic [VW-1:0]    rem_reg, rem_next;
    logic [VW-1:0]    den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [VW:0] rem_shift;
    logic [VW:0] rem_diff;
    logic        fits;

    assign rem_shift = {rem_reg, quo_reg[DW-1]};
    assign fits      = rem_shift >= {1'b0, den_reg};
    assign rem_diff  = rem_shift - {1'b0, den_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = CNT_W'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? rem_diff[VW-1:0] : rem_shift[VW-1:0];
            quo_next = {quo_reg[DW-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

[design/duty_ramp_generator.sv]
// Top level of the trapezoidal PWM duty ramp generator.
// Each accepted item gives one result (duty, phase). A tick or a start, stop or
// down command passes from transfer through ST_EXEC and ST_EMIT to the registered
// result. A change command runs two divisions on the shared serial divider (ramp
// steps, then per-tick increment) before ST_EMIT.
// Writing target_duty, ramp_up_ms, ramp_down_ms or tick_ms recomputes both ramp
// increments through four divisions, during which neither channel is ready; the
// same sequence runs once after reset.
`default_nettype none

module duty_ramp_generator #(
    parameter int FRAC_BITS = drg_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [drg_pkg::ACTION_W-1:0]      action,
    input  wire logic [drg_pkg::DUTY_W-1:0]        new_target,
    input  wire logic [drg_pkg::MS_W-1:0]          transition_ms,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic      [drg_pkg::DUTY_W-1:0]        duty,
    output logic      [drg_pkg::PHASE_W-1:0]       phase,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [drg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [drg_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int AW    = drg_pkg::DUTY_W + FRAC_BITS;
    localparam int DW    = drg_pkg::DUTY_W;
    localparam int MW    = drg_pkg::MS_W;
    localparam int TW    = drg_pkg::TIMER_W;
    localparam int HW    = drg_pkg::HOLD_W;
    localparam int KW    = drg_pkg::TICK_W;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_EXEC   = 7'b0000010,
        ST_L_STEP = 7'b0000100,
        ST_W_STEP = 7'b0001000,
        ST_L_INC  = 7'b0010000,
        ST_W_INC  = 7'b0100000,
        ST_EMIT   = 7'b1000000
    } state_t;

    typedef enum logic [1:0] {
        JOB_UP     = 2'd0,
        JOB_DOWN   = 2'd1,
        JOB_CHANGE = 2'd2
    } job_t;

    state_t state_reg, state_next;
    job_t   job_reg, job_next;

    logic [DW-1:0] target_reg, target_next;
    logic [MW-1:0] up_ms_reg, up_ms_next;
    logic [MW-1:0] down_ms_reg, down_ms_next;
    logic [HW-1:0] hold_ms_reg, hold_ms_next;
    logic          forever_reg, forever_next;
    logic [KW-1:0] tick_reg, tick_next;

    drg_pkg::phase_t phase_reg, phase_next;
    logic [AW-1:0] acc_reg, acc_next;
    logic [DW-1:0] duty_reg, duty_next;
    logic [TW-1:0] timer_reg, timer_next;
    logic [AW-1:0] up_inc_reg, up_inc_next;
    logic [AW-1:0] down_inc_reg, down_inc_next;
    logic [AW-1:0] chg_inc_reg, chg_inc_next;
    logic [DW-1:0] chg_target_reg, chg_target_next;
    logic [DW-1:0] dist_reg, dist_next;
    logic [MW-1:0] steps_reg, steps_next;

    logic [drg_pkg::ACTION_W-1:0] act_reg;
    logic [DW-1:0]                nt_reg;
    logic [MW-1:0]                tms_reg;

    logic                          out_valid_reg, out_valid_next;
    logic [DW-1:0]                 out_duty_reg;
    logic [drg_pkg::PHASE_W-1:0]   out_phase_reg;

    logic in_take;
    logic out_load;

    logic [KW-1:0] tick_eff;
    logic [TW:0]   timer_sum;
    logic [TW-1:0] timer_inc;
    logic [AW-1:0] acc_inc;
    logic [AW:0]   acc_sum;
    logic [AW-1:0] acc_add;
    logic [AW-1:0] acc_sub;
    logic [DW-1:0] duty_add;
    logic [DW-1:0] duty_sub;
    logic [MW-1:0] time_sel;
    logic [DW-1:0] dist_sel;
    logic [MW-1:0] q_steps;

    logic                div_start;
    logic [AW-1:0]       div_dividend;
    logic [MW-1:0]       div_divisor;
    logic [AW-1:0]       div_quotient;
    drg_pkg::div_stat_t  div_stat;

    drg_div #(
        .DW (AW),
        .VW (MW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .status   (div_stat)
    );

    assign in_stall  = (state_reg != ST_IDLE) || cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_take   = in_valid && !in_stall;

    assign tick_eff  = (tick_reg == '0) ? KW'(1) : tick_reg;
    assign timer_sum = {1'b0, timer_reg} + (TW + 1)'(tick_eff);
    assign timer_inc = timer_sum[TW] ? '1 : timer_sum[TW-1:0];

    always_comb
    begin
        case (phase_reg)
            drg_pkg::PH_UP:   acc_inc = up_inc_reg;
            drg_pkg::PH_DOWN: acc_inc = down_inc_reg;
            default:          acc_inc = chg_inc_reg;
        endcase
    end

    assign acc_sum  = {1'b0, acc_reg} + {1'b0, acc_inc};
    assign acc_add  = acc_sum[AW] ? '1 : acc_sum[AW-1:0];
    assign acc_sub  = (acc_inc >= acc_reg) ? '0 : acc_reg - acc_inc;
    assign duty_add = acc_add[AW-1:FRAC_BITS];
    assign duty_sub = acc_sub[AW-1:FRAC_BITS];

    always_comb
    begin
        case (job_reg)
            JOB_UP:
            begin
                time_sel = up_ms_reg;
                dist_sel = target_reg;
            end
            JOB_DOWN:
            begin
                time_sel = down_ms_reg;
                dist_sel = target_reg;
            end
            default:
            begin
                time_sel = tms_reg;
                dist_sel = dist_reg;
            end
        endcase
    end

    assign q_steps = div_quotient[MW-1:0];

    always_comb
    begin
        state_next      = state_reg;
        job_next        = job_reg;
        target_next     = target_reg;
        up_ms_next      = up_ms_reg;
        down_ms_next    = down_ms_reg;
        hold_ms_next    = hold_ms_reg;
        forever_next    = forever_reg;
        tick_next       = tick_reg;
        phase_next      = phase_reg;
        acc_next        = acc_reg;
        duty_next       = duty_reg;
        timer_next      = timer_reg;
        up_inc_next     = up_inc_reg;
        down_inc_next   = down_inc_reg;
        chg_inc_next    = chg_inc_reg;
        chg_target_next = chg_target_reg;
        dist_next       = dist_reg;
        steps_next      = steps_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_load        = 1'b0;
        div_start       = 1'b0;
        div_dividend    = AW'(time_sel);
        div_divisor     = MW'(tick_eff);

        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_valid)
                begin
                    case (drg_pkg::cfg_reg_t'(cfg_index))
                        drg_pkg::REG_TARGET:
                        begin
                            target_next = cfg_data[DW-1:0];
                            job_next    = JOB_UP;
                            state_next  = ST_L_STEP;
                        end
                        drg_pkg::REG_UP_MS:
                        begin
                            up_ms_next = cfg_data[MW-1:0];
                            job_next   = JOB_UP;
                            state_next = ST_L_STEP;
                        end
                        drg_pkg::REG_DOWN_MS:
                        begin
                            down_ms_next = cfg_data[MW-1:0];
                            job_next     = JOB_UP;
                            state_next   = ST_L_STEP;
                        end
                        drg_pkg::REG_STEADY:
                        begin
                            hold_ms_next = HW'({{(HW - drg_pkg::SEC_W){1'b0}},
                                                cfg_data[drg_pkg::SEC_W-1:0]}
                                               * HW'(drg_pkg::MS_PER_S));
                        end
                        drg_pkg::REG_FOREVER:
                        begin
                            forever_next = cfg_data[0];
                        end
                        drg_pkg::REG_TICK:
                        begin
                            tick_next  = cfg_data[KW-1:0];
                            job_next   = JOB_UP;
                            state_next = ST_L_STEP;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                state_next = ST_EMIT;
                case (drg_pkg::action_t'(act_reg))
                    drg_pkg::ACT_TICK:
                    begin
                        if (phase_reg != drg_pkg::PH_WAIT)
                        begin
                            timer_next = timer_inc;
                        end
                        case (phase_reg)
                            drg_pkg::PH_UP:
                            begin
                                if (duty_reg <= target_reg)
                                begin
                                    acc_next  = acc_add;
                                    duty_next = duty_add;
                                    if (duty_add >= target_reg)
                                    begin
                                        duty_next  = target_reg;
                                        phase_next = drg_pkg::PH_STEADY;
                                        timer_next = '0;
                                    end
                                end
                            end
                            drg_pkg::PH_STEADY:
                            begin
                                if (!forever_reg && timer_inc >= TW'(hold_ms_reg))
                                begin
                                    phase_next = drg_pkg::PH_DOWN;
                                    timer_next = '0;
                                end
                            end
                            drg_pkg::PH_CHANGE:
                            begin
                                if (duty_reg < chg_target_reg)
                                begin
                                    acc_next  = acc_add;
                                    duty_next = duty_add;
                                    if (duty_add >= chg_target_reg)
                                    begin
                                        duty_next  = chg_target_reg;
                                        phase_next = drg_pkg::PH_STEADY;
                                        timer_next = '0;
                                    end
                                end
                                else if (duty_reg > chg_target_reg)
                                begin
                                    acc_next  = acc_sub;
                                    duty_next = duty_sub;
                                    if (duty_sub <= chg_target_reg)
                                    begin
                                        duty_next  = chg_target_reg;
                                        phase_next = drg_pkg::PH_STEADY;
                                        timer_next = '0;
                                    end
                                end
                                else
                                begin
                                    duty_next  = chg_target_reg;
                                    phase_next = drg_pkg::PH_STEADY;
                                    timer_next = '0;
                                end
                            end
                            drg_pkg::PH_DOWN:
                            begin
                                acc_next  = acc_sub;
                                duty_next = duty_sub;
                                if (duty_sub == '0)
                                begin
                                    phase_next = drg_pkg::PH_WAIT;
                                    timer_next = '0;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    drg_pkg::ACT_UP:
                    begin
                        phase_next = drg_pkg::PH_UP;
                    end
                    drg_pkg::ACT_DOWN:
                    begin
                        phase_next = drg_pkg::PH_DOWN;
                        timer_next = '0;
                    end
                    drg_pkg::ACT_STOP:
                    begin
                        phase_next = drg_pkg::PH_WAIT;
                        acc_next   = '0;
                        duty_next  = '0;
                        timer_next = '0;
                    end
                    drg_pkg::ACT_CHANGE:
                    begin
                        chg_target_next = nt_reg;
                        dist_next = (nt_reg > duty_reg) ? nt_reg - duty_reg
                                                        : duty_reg - nt_reg;
                        if (nt_reg == duty_reg)
                        begin
                            phase_next = drg_pkg::PH_STEADY;
                            timer_next = '0;
                        end
                        else
                        begin
                            phase_next = drg_pkg::PH_CHANGE;
                        end
                        job_next   = JOB_CHANGE;
                        state_next = ST_L_STEP;
                    end
                    default:
                    begin
                    end
                endcase
            end

            ST_L_STEP:
            begin
                div_start    = 1'b1;
                div_dividend = AW'(time_sel);
                div_divisor  = MW'(tick_eff);
                state_next   = ST_W_STEP;
            end

            ST_W_STEP:
            begin
                if (div_stat.done)
                begin
                    steps_next = (q_steps == '0) ? MW'(1) : q_steps;
                    state_next = ST_L_INC;
                end
            end

            ST_L_INC:
            begin
                div_start    = 1'b1;
                div_dividend = {dist_sel, {FRAC_BITS{1'b0}}};
                div_divisor  = steps_reg;
                state_next   = ST_W_INC;
            end

            ST_W_INC:
            begin
                if (div_stat.done)
                begin
                    case (job_reg)
                        JOB_UP:
                        begin
                            up_inc_next = div_quotient;
                            job_next    = JOB_DOWN;
                            state_next  = ST_L_STEP;
                        end
                        JOB_DOWN:
                        begin
                            down_inc_next = div_quotient;
                            state_next    = ST_IDLE;
                        end
                        default:
                        begin
                            chg_inc_next = div_quotient;
                            state_next   = ST_EMIT;
                        end
                    endcase
                end
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_L_STEP;
            job_reg        <= JOB_UP;
            target_reg     <= drg_pkg::TARGET_RST;
            up_ms_reg      <= drg_pkg::RAMP_MS_RST;
            down_ms_reg    <= drg_pkg::RAMP_MS_RST;
            hold_ms_reg    <= HW'(drg_pkg::STEADY_RST) * HW'(drg_pkg::MS_PER_S);
            forever_reg    <= 1'b0;
            tick_reg       <= drg_pkg::TICK_RST;
            phase_reg      <= drg_pkg::PH_WAIT;
            acc_reg        <= '0;
            duty_reg       <= '0;
            timer_reg      <= '0;
            up_inc_reg     <= '0;
            down_inc_reg   <= '0;
            chg_inc_reg    <= '0;
            chg_target_reg <= '0;
            dist_reg       <= '0;
            steps_reg      <= MW'(1);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            job_reg        <= job_next;
            target_reg     <= target_next;
            up_ms_reg      <= up_ms_next;
            down_ms_reg    <= down_ms_next;
            hold_ms_reg    <= hold_ms_next;
            forever_reg    <= forever_next;
            tick_reg       <= tick_next;
            phase_reg      <= phase_next;
            acc_reg        <= acc_next;
            duty_reg       <= duty_next;
            timer_reg      <= timer_next;
            up_inc_reg     <= up_inc_next;
            down_inc_reg   <= down_inc_next;
            chg_inc_reg    <= chg_inc_next;
            chg_target_reg <= chg_target_next;
            dist_reg       <= dist_next;
            steps_reg      <= steps_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            act_reg <= action;
            nt_reg  <= new_target;
            tms_reg <= transition_ms;
        end
        if (out_load)
        begin
            out_duty_reg  <= duty_reg;
            out_phase_reg <= phase_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign duty      = out_duty_reg;
    assign phase     = out_phase_reg;

`ifndef ASSERT_OFF
    // wait phase is only entered with the duty at zero
    a_wait_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == drg_pkg::PH_WAIT) |-> (duty_reg == '0))
        else $error("wait phase with non-zero duty");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_one_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        !(cfg_valid && cfg_ready && in_valid && !in_stall))
        else $error("config write and item transfer in the same cycle");

    a_emit_after_item: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("result not presented after load");
`endif

endmodule

`default_nettype wire
